// ===== design/m3inv_pkg.sv =====
// Shared defaults for the 3x3 matrix inverse block.
package m3inv_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== design/m3inv_div.sv =====
// Pipelined restoring divider lane: one quotient bit per stage, W stages.
module m3inv_div #(
	parameter int W  = m3inv_pkg::DATA_WIDTH_DEF,
	parameter int DW = 3 * m3inv_pkg::DATA_WIDTH_DEF + 3,
	parameter int XW = 4 * m3inv_pkg::DATA_WIDTH_DEF + 3
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] num,
	input  logic [DW-1:0] div,
	input  logic          neg,
	input  logic          ovf,
	output logic [W-1:0]  quo,
	output logic          neg_o,
	output logic          ovf_o
);

	logic [XW-1:0] rem_s [W-1];
	logic [DW-1:0] dv_s  [W-1];
	logic [W-1:0]  q_s   [W];
	logic          neg_s [W];
	logic          ovf_s [W];

	for (genvar j = 0; j < W; j++) begin : g_stage
		logic [XW-1:0] rin;
		logic [DW-1:0] din;
		logic [W-1:0]  qin;
		logic          nin;
		logic          oin;
		logic [XW-1:0] dsh;
		logic          ge;

		if (j == 0) begin : g_first
			assign rin = num;
			assign din = div;
			assign qin = '0;
			assign nin = neg;
			assign oin = ovf;
		end else begin : g_next
			assign rin = rem_s[j-1];
			assign din = dv_s[j-1];
			assign qin = q_s[j-1];
			assign nin = neg_s[j-1];
			assign oin = ovf_s[j-1];
		end

		// trial subtract of divisor weighted by this stage's quotient bit
		assign dsh = XW'(din) << (W - 1 - j);
		assign ge  = (rin >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j]   <= {qin[W-2:0], ge};
				neg_s[j] <= nin;
				ovf_s[j] <= oin;
			end
		end

		if (j < W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? (rin - dsh) : rin;
					dv_s[j]  <= din;
				end
			end
		end
	end

	assign quo   = q_s[W-1];
	assign neg_o = neg_s[W-1];
	assign ovf_o = ovf_s[W-1];

endmodule

// ===== design/matrix3x3_inverse_determinant.sv =====
// Top level: 3x3 fixed-point matrix inverse by adjugate over determinant.
//
// Input channel s_*: one transfer carries a whole matrix, nine signed
// Q(W-F).F entries packed in s_tdata. Output channel m_*: one transfer per
// matrix with the nine inverse entries and the determinant in m_tdata and
// the singular flag in m_tuser.
// Pipeline: W+9 register stages from the input transfer to the offered result.
// Throughput: one matrix per cycle while the output is not stalled. Nine
// divider lanes resolve one quotient bit per stage over W stages; the other
// nine stages register the input, form the products, the adjugate, the
// determinant, the divider operands and the signed, saturated outputs.
// Zero determinant: divisor becomes 2^F, so the adjugate itself comes out
// (truncated toward zero, saturated) and singular is set.
// All values truncate toward zero and saturate to the signed W-bit range.
// Reset clears every valid bit, that of the input skid register included;
// nothing is pending afterwards.
// Stall: while m_tready is low with a result offered, the whole pipeline
// holds. The input skid register still takes one more transfer, so
// s_tready drops in the cycle after it and no combinational path runs from
// m_tready to s_tready.
module matrix3x3_inverse_determinant #(
	parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// m11, m12, m13, m21, m22, m23, m31, m32, m33 from bit 0 up
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33,
	// determinant from bit 0 up
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((10*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
	// singular
	output logic [0:0]                             m_tuser
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int IW = ((9 * W + 7) / 8) * 8;
	localparam int AW = 2 * W + 1;           // adjugate entry
	localparam int TW = 3 * W + 1;           // determinant term
	localparam int DW = 3 * W + 3;           // determinant
	localparam int NW = AW + 2 * F;          // scaled numerator
	localparam int XW = (NW > DW + W) ? NW : DW + W;
	localparam int NS = W + 9;               // register stages

	// cofactor operands: adj[i] = e[IX]*e[IY] - e[IU]*e[IV]
	localparam int IX [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int IY [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int IU [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int IV [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

	// sign applied to a magnitude, then clamped to the signed range
	function automatic logic [W-1:0] sat_val(input logic neg, input logic ovf,
	                                         input logic [W-1:0] mag);
		logic [W-1:0] r;
		if (ovf)
			r = neg ? SMIN : SMAX;
		else if (neg)
			r = (mag > SMIN) ? SMIN : (~mag + 1'b1);
		else
			r = mag[W-1] ? SMAX : mag;
		return r;
	endfunction

	// ---------------- flow control ----------------
	logic          en;
	logic [NS-1:0] v_q;
	logic          skid_v_q;
	logic [IW-1:0] skid_q;
	logic          in_v;
	logic [IW-1:0] in_data;

	assign en       = !v_q[NS-1] || m_tready;
	assign s_tready = !skid_v_q;
	assign in_v     = skid_v_q || s_tvalid;
	assign in_data  = skid_v_q ? skid_q : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q      <= '0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_q      <= {v_q[NS-2:0], in_v};
				skid_v_q <= 1'b0;
			end else if (s_tvalid && !skid_v_q) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && !skid_v_q)
			skid_q <= s_tdata;
	end

	// ---------------- S1: matrix entries ----------------
	logic signed [W-1:0] e_s1 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				e_s1[i] <= in_data[W*i +: W];
		end
	end

	// ---------------- S2: cofactor products ----------------
	logic signed [2*W-1:0] pa_s2 [9];
	logic signed [2*W-1:0] pb_s2 [9];
	logic signed [W-1:0]   r1_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				pa_s2[i] <= (2*W)'(e_s1[IX[i]]) * (2*W)'(e_s1[IY[i]]);
				pb_s2[i] <= (2*W)'(e_s1[IU[i]]) * (2*W)'(e_s1[IV[i]]);
			end
			for (int j = 0; j < 3; j++)
				r1_s2[j] <= e_s1[j];
		end
	end

	// ---------------- S3: adjugate ----------------
	logic signed [AW-1:0] adj_s3 [9];
	logic signed [W-1:0]  r1_s3  [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				adj_s3[i] <= AW'(pa_s2[i]) - AW'(pb_s2[i]);
			r1_s3 <= r1_s2;
		end
	end

	// ---------------- S4: determinant partial products ----------------
	// first row times first adjugate column, adjugate split into halves
	// (low half as an unsigned magnitude, high half signed)
	logic signed [AW-1:0] pl_s4  [3];
	logic signed [AW-1:0] ph_s4  [3];
	logic signed [AW-1:0] adj_s4 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pl_s4[j] <= AW'(r1_s3[j])
				          * AW'($signed({1'b0, adj_s3[3*j][W-1:0]}));
				ph_s4[j] <= AW'(r1_s3[j]) * AW'($signed(adj_s3[3*j][AW-1:W]));
			end
			adj_s4 <= adj_s3;
		end
	end

	// ---------------- S5: determinant terms ----------------
	logic signed [TW-1:0] t_s5   [3];
	logic signed [AW-1:0] adj_s5 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				t_s5[j] <= (TW'(ph_s4[j]) <<< W) + TW'(pl_s4[j]);
			adj_s5 <= adj_s4;
		end
	end

	// ---------------- S6: determinant ----------------
	logic signed [DW-1:0] d_s6;
	logic signed [AW-1:0] adj_s6 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6   <= DW'(t_s5[0]) + DW'(t_s5[1]) + DW'(t_s5[2]);
			adj_s6 <= adj_s5;
		end
	end

	// ---------------- S7: magnitudes and signs ----------------
	logic [DW-1:0] dabs_s7;
	logic          dneg_s7;
	logic          dzero_s7;
	logic [AW-1:0] aabs_s7 [9];
	logic          aneg_s7 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			dabs_s7  <= d_s6[DW-1] ? DW'(-d_s6) : DW'(d_s6);
			dneg_s7  <= d_s6[DW-1];
			dzero_s7 <= (d_s6 == '0);
			for (int i = 0; i < 9; i++) begin
				aabs_s7[i] <= adj_s6[i][AW-1] ? AW'(-adj_s6[i]) : AW'(adj_s6[i]);
				aneg_s7[i] <= adj_s6[i][AW-1];
			end
		end
	end

	// ---------------- S8: divider operands, determinant output ----------------
	logic [XW-1:0] num_s8 [9];
	logic [DW-1:0] div_s8;
	logic          neg_s8 [9];
	logic          ovf_s8 [9];
	logic [W-1:0]  det_s8;
	logic          sing_s8;
	logic [DW-1:0] div_c;
	logic [XW-1:0] num_c [9];
	logic [DW-1:0] dmag_c;

	always_comb begin
		// zero determinant: divide by one, i.e. unscale the adjugate by 2^F
		div_c  = dzero_s7 ? (DW'(1) << F) : dabs_s7;
		dmag_c = dabs_s7 >> (2 * F);
		for (int i = 0; i < 9; i++)
			num_c[i] = dzero_s7 ? XW'(aabs_s7[i]) : (XW'(aabs_s7[i]) << (2 * F));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s8 <= div_c;
			for (int i = 0; i < 9; i++) begin
				num_s8[i] <= num_c[i];
				neg_s8[i] <= aneg_s7[i] ^ dneg_s7;
				// quotient would need more than W magnitude bits
				ovf_s8[i] <= (num_c[i] >= (XW'(div_c) << W));
			end
			det_s8  <= sat_val(dneg_s7, |dmag_c[DW-1:W], dmag_c[W-1:0]);
			sing_s8 <= dzero_s7;
		end
	end

	// ---------------- divider lanes: W stages ----------------
	logic [W-1:0] quo  [9];
	logic         qneg [9];
	logic         qovf [9];

	for (genvar i = 0; i < 9; i++) begin : g_lane
		m3inv_div #(
			.W  (W),
			.DW (DW),
			.XW (XW)
		) u_div (
			.clk   (clk),
			.en    (en),
			.num   (num_s8[i]),
			.div   (div_s8),
			.neg   (neg_s8[i]),
			.ovf   (ovf_s8[i]),
			.quo   (quo[i]),
			.neg_o (qneg[i]),
			.ovf_o (qovf[i])
		);
	end

	// determinant and flag ride alongside the divider stages
	logic [W-1:0] det_sd  [W];
	logic         sing_sd [W];

	always_ff @(posedge clk) begin
		if (en) begin
			det_sd[0]  <= det_s8;
			sing_sd[0] <= sing_s8;
			for (int k = 1; k < W; k++) begin
				det_sd[k]  <= det_sd[k-1];
				sing_sd[k] <= sing_sd[k-1];
			end
		end
	end

	// ---------------- output stage: sign and saturate ----------------
	logic [W-1:0] inv_so [9];
	logic [W-1:0] det_so;
	logic         sing_so;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				inv_so[i] <= sat_val(qneg[i], qovf[i], quo[i]);
			det_so  <= det_sd[W-1];
			sing_so <= sing_sd[W-1];
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 9; i++)
			m_tdata[W*i +: W] = inv_so[i];
		m_tdata[9*W +: W] = det_so;
	end

	assign m_tuser  = sing_so;
	assign m_tvalid = v_q[NS-1];

`ifndef SYNTH
	// skid register only fills while the pipeline is stalled
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(!en))
		else $error("skid register filled while pipeline advanced");

	// a stall freezes every valid bit in the pipeline
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("pipeline valids moved during a stall");

	// a singular result always reports a zero determinant
	a_singular_det: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[9*W +: W] == '0))
		else $error("singular flag with nonzero determinant");
`endif

endmodule
